// File: design/timer_expiry_scheduler_top_assert.svh
// Assertion macros for the timer expiry scheduler top level.
// Used by timer_expiry_scheduler_top.sv; expects i_clk and i_rst_n in scope.
`ifndef TIMER_EXPIRY_SCHEDULER_TOP_ASSERT_SVH
`define TIMER_EXPIRY_SCHEDULER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TES_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tes: same-cycle check failed");
// next-cycle implication
`define TES_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tes: next-cycle check failed");
`else
`define TES_ASSERT_IMP(label, ante, cons)
`define TES_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: design/tes_pkg.sv
// Shared constants, codes and controller/datapath types for the timer scheduler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tes_pkg;

    localparam int TIMERS      = 16;
    localparam int TIME_BITS   = 48;
    localparam int PERIOD_BITS = 32;
    localparam int ID_W        = 4;
    localparam int KIND_W      = 2;
    localparam int SLOT_W      = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int CNT_W       = $clog2(TIMERS + 1);

    typedef enum logic [1:0] {
        KIND_ADD   = 2'd0,
        KIND_DEL   = 2'd1,
        KIND_CHECK = 2'd2,
        KIND_NOP   = 2'd3
    } t_kind;

    // what the datapath does with expiry data coming back from memory
    typedef enum logic [1:0] {
        SCAN_NONE,
        SCAN_DUE,
        SCAN_SEL,
        SCAN_SUM
    } t_scan;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DUE,
        ST_SEL,
        ST_SEL_END,
        ST_FIRE,
        ST_SUM,
        ST_EMIT
    } t_state;

    typedef struct packed {
        t_scan             scan;
        logic [SLOT_W-1:0] addr;
        logic              load;
        logic              do_add;
        logic              do_del;
        logic              clr_sel;
        logic              clr_sum;
        logic              fire_log;
        logic              fire_upd;
        logic              emit_adv;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  found;
        logic  emit_last;
    } t_stat;

endpackage

`default_nettype wire

// File: design/tes_ifs.sv
// Valid/ready channel interfaces for the timer scheduler request and record streams.
// Depends on tes_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tes_in_if import tes_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [KIND_W-1:0]      kind;
    logic [ID_W-1:0]        timer_id;
    logic [PERIOD_BITS-1:0] interval_ms;
    logic                   periodic;
    logic [TIME_BITS-1:0]   now_ms;

    modport source (output valid, kind, timer_id, interval_ms, periodic, now_ms,
                    input ready);
    modport sink   (input valid, kind, timer_id, interval_ms, periodic, now_ms,
                    output ready);
endinterface

interface tes_out_if import tes_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 fired;
    logic [ID_W-1:0]      fired_id;
    logic                 pending;
    logic [TIME_BITS-1:0] next_expire_ms;
    logic                 last;

    modport source (output valid, fired, fired_id, pending, next_expire_ms, last,
                    input ready);
    modport sink   (input valid, fired, fired_id, pending, next_expire_ms, last,
                    output ready);
endinterface

`default_nettype wire

// File: design/timer_expiry_scheduler_top.sv
// Timer expiry scheduler: a table of TIMERS slots armed, freed and checked per millisecond item.
// Takes one request transaction and returns its fired records followed by one summary
// record. The design keeps the slot table in a one-read-port expiry memory and walks it.
//
// Flow: one request is handled at a time. Every scan of the table reads one slot per
// cycle from the expiry memory and then drains the registered read. An add, a delete
// or a no-op is accepted, executed and followed by one summary scan before its summary
// record is presented. A check runs a due scan, then a selection scan and a re-arm for
// each fired slot, then a final selection scan and a summary scan, and then returns
// n+1 record transactions for n fired slots.
// Fired slots are picked by repeated minimum scans over the due set, earliest expiry
// first and the lower slot on a tie; a periodic slot is re-armed at now plus its
// interval and does not fire twice in one check. pending and next_expire_ms carry the
// state after the whole request in every record. Expiry arithmetic wraps at
// 2^TIME_BITS. Expiry times and intervals of slots never armed are not cleared at reset;
// they are only read for active slots.
// Depends on tes_pkg, tes_ifs, tes_ctrl, tes_dp and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "timer_expiry_scheduler_top_assert.svh"

module timer_expiry_scheduler_top import tes_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tes_in_if.sink    i_req,
    tes_out_if.source o_rsp
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencer: owns both handshakes
    tes_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // datapath: slot table, scan results and the record payload
    tes_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_kind           (i_req.kind),
        .i_timer_id       (i_req.timer_id),
        .i_interval_ms    (i_req.interval_ms),
        .i_periodic       (i_req.periodic),
        .i_now_ms         (i_req.now_ms),
        .o_fired          (o_rsp.fired),
        .o_fired_id       (o_rsp.fired_id),
        .o_pending        (o_rsp.pending),
        .o_next_expire_ms (o_rsp.next_expire_ms),
        .o_last           (o_rsp.last)
    );

    // records are only presented while no new request can enter
    `TES_ASSERT_IMP(a_out_excl_in, o_rsp.valid, !i_req.ready)
    // an accepted request always goes through execute before any record
    `TES_ASSERT_NXT(a_accept_no_rec, i_req.valid && i_req.ready, !o_rsp.valid)
    // the summary transaction returns the block to taking requests
    `TES_ASSERT_NXT(a_last_to_idle, o_rsp.valid && o_rsp.ready && o_rsp.last, i_req.ready)
    // no pending slot means a zero next expiry
    `TES_ASSERT_IMP(a_idle_next_zero, o_rsp.valid && !o_rsp.pending, o_rsp.next_expire_ms == '0)

endmodule

`default_nettype wire

// File: design/tes_ctrl.sv
// Sequencer for the timer scheduler: walks the slot scans and record output.
// Depends on tes_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tes_ctrl import tes_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_scan_end;
    logic             w_scanning;

    assign w_scan_end = (r_cnt == CNT_W'(TIMERS));
    assign w_scanning = (r_state == ST_DUE) || (r_state == ST_SEL) || (r_state == ST_SUM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // slot counter: one address per cycle, then an end count that drains the read
    always_comb begin
        if (w_scanning && !w_scan_end) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else begin
            n_cnt = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = (i_stat.kind == KIND_CHECK) ? ST_DUE : ST_SUM;
            end
            ST_DUE: begin
                if (w_scan_end) n_state = ST_SEL;
            end
            ST_SEL: begin
                if (w_scan_end) n_state = ST_SEL_END;
            end
            ST_SEL_END: begin
                n_state = i_stat.found ? ST_FIRE : ST_SUM;
            end
            ST_FIRE: begin
                n_state = ST_SEL;
            end
            ST_SUM: begin
                if (w_scan_end) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_out_ready && i_stat.emit_last) n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd.addr  = SLOT_W'(r_cnt);
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_EXEC: begin
                o_cmd.do_add  = (i_stat.kind == KIND_ADD);
                o_cmd.do_del  = (i_stat.kind == KIND_DEL);
                o_cmd.clr_sum = (i_stat.kind != KIND_CHECK);
            end
            ST_DUE: begin
                o_cmd.scan    = w_scan_end ? SCAN_NONE : SCAN_DUE;
                o_cmd.clr_sel = w_scan_end;
            end
            ST_SEL: begin
                o_cmd.scan = w_scan_end ? SCAN_NONE : SCAN_SEL;
            end
            ST_SEL_END: begin
                o_cmd.fire_log = i_stat.found;
                o_cmd.clr_sum  = !i_stat.found;
            end
            ST_FIRE: begin
                o_cmd.fire_upd = 1'b1;
                o_cmd.clr_sel  = 1'b1;
            end
            ST_SUM: begin
                o_cmd.scan = w_scan_end ? SCAN_NONE : SCAN_SUM;
            end
            ST_EMIT: begin
                o_out_valid    = 1'b1;
                o_cmd.emit_adv = i_out_ready && !i_stat.emit_last;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/tes_dp.sv
// Datapath for the timer scheduler: slot memories, scan accumulators, fire list.
// Depends on tes_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tes_dp import tes_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_stat                  o_stat,
    input  logic [KIND_W-1:0]      i_kind,
    input  logic [ID_W-1:0]        i_timer_id,
    input  logic [PERIOD_BITS-1:0] i_interval_ms,
    input  logic                   i_periodic,
    input  logic [TIME_BITS-1:0]   i_now_ms,
    output logic                   o_fired,
    output logic [ID_W-1:0]        o_fired_id,
    output logic                   o_pending,
    output logic [TIME_BITS-1:0]   o_next_expire_ms,
    output logic                   o_last
);

    // latched item
    t_kind                  r_kind;
    logic [ID_W-1:0]        r_id;
    logic [PERIOD_BITS-1:0] r_interval;
    logic                   r_periodic;
    logic [TIME_BITS-1:0]   r_now;

    // slot storage
    logic [TIME_BITS-1:0]   r_exp_mem [TIMERS];
    logic [PERIOD_BITS-1:0] r_per_mem [TIMERS];
    logic [TIME_BITS-1:0]   r_exp_q;
    logic [PERIOD_BITS-1:0] r_per_q;
    logic [TIMERS-1:0]      r_active;
    logic [TIMERS-1:0]      r_repeat;
    logic [TIMERS-1:0]      r_due;

    // scan tracking
    t_scan                  r_scan_d;
    logic [SLOT_W-1:0]      r_idx_d;
    logic                   r_found;
    logic [SLOT_W-1:0]      r_best_idx;
    logic [TIME_BITS-1:0]   r_best_exp;
    logic                   r_pend;
    logic [TIME_BITS-1:0]   r_nexp;

    // fire list and record output
    logic [SLOT_W-1:0]      r_order [TIMERS];
    logic [CNT_W-1:0]       r_nfire;
    logic [CNT_W-1:0]       r_emit_k;

    logic                   w_id_ok;
    logic [SLOT_W-1:0]      w_id_slot;
    logic                   w_add_we;
    logic [PERIOD_BITS-1:0] w_add_b;
    logic [TIME_BITS-1:0]   w_sum;
    logic                   w_exp_we;
    logic [SLOT_W-1:0]      w_exp_wa;
    logic                   w_sel_hit;
    logic                   w_sum_hit;

    assign w_id_ok   = (int'(r_id) < TIMERS);
    assign w_id_slot = SLOT_W'(r_id);
    assign w_add_we  = i_cmd.do_add && w_id_ok;

    // one adder serves both arming on add and re-arming on fire, modulo 2^TIME_BITS
    assign w_add_b   = i_cmd.do_add ? r_interval : r_per_q;
    assign w_sum     = r_now + TIME_BITS'(w_add_b);
    assign w_exp_we  = w_add_we || (i_cmd.fire_upd && r_repeat[r_best_idx]);
    assign w_exp_wa  = i_cmd.do_add ? w_id_slot : r_best_idx;

    // strict compare keeps the lower slot on equal expiry (ascending scan)
    assign w_sel_hit = (r_scan_d == SCAN_SEL) && r_due[r_idx_d]
                       && (!r_found || (r_exp_q < r_best_exp));
    assign w_sum_hit = (r_scan_d == SCAN_SUM) && r_active[r_idx_d]
                       && (!r_pend || (r_exp_q < r_nexp));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind     <= t_kind'(i_kind);
            r_id       <= i_timer_id;
            r_interval <= i_interval_ms;
            r_periodic <= i_periodic;
            r_now      <= i_now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exp_we) begin
            r_exp_mem[w_exp_wa] <= w_sum;
        end
        r_exp_q <= r_exp_mem[i_cmd.addr];
    end

    // period is read at the selected slot; registered, so it is valid the cycle after selection settles
    always_ff @(posedge i_clk) begin
        if (w_add_we) begin
            r_per_mem[w_id_slot] <= r_interval;
        end
        r_per_q <= r_per_mem[r_best_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_repeat <= '0;
            r_due    <= '0;
            r_scan_d <= SCAN_NONE;
            r_found  <= 1'b0;
            r_pend   <= 1'b0;
            r_nfire  <= '0;
            r_emit_k <= '0;
        end else begin
            r_scan_d <= i_cmd.scan;
            if (i_cmd.load) begin
                r_nfire  <= '0;
                r_emit_k <= '0;
            end
            if (w_add_we) begin
                r_active[w_id_slot] <= 1'b1;
                r_repeat[w_id_slot] <= r_periodic;
            end
            if (i_cmd.do_del && w_id_ok) begin
                r_active[w_id_slot] <= 1'b0;
            end
            if (r_scan_d == SCAN_DUE) begin
                r_due[r_idx_d] <= r_active[r_idx_d] && (r_exp_q <= r_now);
            end
            if (w_sel_hit) begin
                r_found <= 1'b1;
            end
            if (w_sum_hit) begin
                r_pend <= 1'b1;
            end
            if (i_cmd.clr_sel) begin
                r_found <= 1'b0;
            end
            if (i_cmd.clr_sum) begin
                r_pend <= 1'b0;
            end
            if (i_cmd.fire_log) begin
                r_due[r_best_idx] <= 1'b0;
                r_nfire           <= r_nfire + CNT_W'(1);
            end
            if (i_cmd.fire_upd && !r_repeat[r_best_idx]) begin
                r_active[r_best_idx] <= 1'b0;
            end
            if (i_cmd.emit_adv) begin
                r_emit_k <= r_emit_k + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx_d <= i_cmd.addr;
        if (w_sel_hit) begin
            r_best_idx <= r_idx_d;
            r_best_exp <= r_exp_q;
        end
        if (w_sum_hit) begin
            r_nexp <= r_exp_q;
        end
        if (i_cmd.fire_log) begin
            r_order[SLOT_W'(r_nfire)] <= r_best_idx;
        end
    end

    assign o_fired          = (r_emit_k != r_nfire);
    assign o_fired_id       = o_fired ? ID_W'(r_order[SLOT_W'(r_emit_k)]) : '0;
    assign o_pending        = r_pend;
    assign o_next_expire_ms = r_pend ? r_nexp : '0;
    assign o_last           = !o_fired;

    assign o_stat.kind      = r_kind;
    assign o_stat.found     = r_found;
    assign o_stat.emit_last = !o_fired;

endmodule

`default_nettype wire
